// ===== rtl/core/packet_token_bucket_shaper_defines.svh =====
// Assertion macros used by the shaper's top-level RTL.
`ifndef PACKET_TOKEN_BUCKET_SHAPER_DEFINES_SVH
`define PACKET_TOKEN_BUCKET_SHAPER_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pts_pkg.sv =====
package pts_pkg;

	localparam int PKT_HANDLE_W = 16;
	localparam int PROTO_W      = 8;
	localparam int ADDR_W       = 32;
	localparam int TOKEN_W      = 8;
	localparam int HELD_W       = 5;
	localparam int VERDICT_W    = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	localparam int DEF_HOLD_DEPTH  = 16;
	localparam int DEF_HANDLE_BITS = 16;

	localparam logic [PROTO_W-1:0] RST_MATCH_PROTOCOL = 8'd17;
	localparam logic [ADDR_W-1:0]  RST_EXEMPT_ADDRESS = 32'd16777343;
	localparam logic [TOKEN_W-1:0] RST_TOKEN_CAP      = 8'd10;
	localparam logic [HELD_W-1:0]  RST_HOLD_LIMIT     = 5'd10;

	localparam logic [CFG_IDX_W-1:0] REG_MATCH_PROTOCOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXEMPT_ADDRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_CAP      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT     = 2'd3;

	localparam logic [VERDICT_W-1:0] VERDICT_PASS    = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_HELD    = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_DROPPED = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'd3;

	// Classification of one queued beat.
	typedef struct packed {
		logic tick;
		logic limited;
	} pts_cls_t;

	// Stored handle width: the handle field never carries more than 16 bits.
	function automatic int pts_store_w(input int handle_bits);
		return (handle_bits < PKT_HANDLE_W) ? handle_bits : PKT_HANDLE_W;
	endfunction

endpackage

// ===== rtl/core/pts_ram.sv =====
module pts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/pts_front.sv =====
module pts_front #(
	parameter int HANDLE_BITS = pts_pkg::DEF_HANDLE_BITS
) (
	input  logic                                            func,
	input  logic [pts_pkg::PROTO_W-1:0]                     protocol,
	input  logic [pts_pkg::ADDR_W-1:0]                      dest_address,
	input  logic [pts_pkg::PKT_HANDLE_W-1:0]                packet_handle,
	input  logic [pts_pkg::PROTO_W-1:0]                     match_protocol,
	input  logic [pts_pkg::ADDR_W-1:0]                      exempt_address,
	output pts_pkg::pts_cls_t                               cls,
	output logic [pts_pkg::pts_store_w(HANDLE_BITS)-1:0]    handle
);

	import pts_pkg::*;

	localparam int HW = pts_store_w(HANDLE_BITS);

	always_comb begin
		cls.tick    = func;
		cls.limited = (protocol == match_protocol) && (dest_address != exempt_address);
	end

	assign handle = packet_handle[HW-1:0];

endmodule

// ===== rtl/core/pts_queue.sv =====
module pts_queue #(
	parameter int WIDTH = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/core/pts_back.sv =====
module pts_back #(
	parameter int HOLD_DEPTH  = pts_pkg::DEF_HOLD_DEPTH,
	parameter int HANDLE_BITS = pts_pkg::DEF_HANDLE_BITS
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         ent_valid,
	input  pts_pkg::pts_cls_t                            ent_cls,
	input  logic [pts_pkg::pts_store_w(HANDLE_BITS)-1:0] ent_handle,
	output logic                                         ent_pop,
	input  logic [pts_pkg::TOKEN_W-1:0]                  token_cap,
	input  logic [pts_pkg::HELD_W-1:0]                   hold_limit,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic [pts_pkg::VERDICT_W-1:0]                verdict,
	output logic                                         release_valid,
	output logic [pts_pkg::PKT_HANDLE_W-1:0]             release_handle,
	output logic [pts_pkg::TOKEN_W-1:0]                  tokens_now,
	output logic [pts_pkg::HELD_W-1:0]                   held_now
);

	import pts_pkg::*;

	localparam int HW = pts_store_w(HANDLE_BITS);
	localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	// The hold limit register cannot exceed 31, so a deep store caps nothing.
	localparam logic [HELD_W-1:0] DEPTH_CAP = (HOLD_DEPTH < 32) ? HELD_W'(HOLD_DEPTH) : 5'd31;

	logic [TOKEN_W-1:0]   tok_q;
	logic [HELD_W-1:0]    held_q;
	logic                 out_valid_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic                 rel_q;

	logic                 adv;
	logic                 exec;
	logic [HELD_W-1:0]    eff_limit;
	logic [TOKEN_W-1:0]   tok_d;
	logic [HELD_W-1:0]    held_d;
	logic [VERDICT_W-1:0] verdict_d;
	logic                 rel_d;
	logic                 we;
	logic                 re;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic [HW-1:0]        rdata;

	assign adv       = !out_valid_q || !out_stall;
	assign exec      = ent_valid && adv;
	assign ent_pop   = exec;
	assign eff_limit = (hold_limit < DEPTH_CAP) ? hold_limit : DEPTH_CAP;
	assign waddr     = AW'(held_q);
	assign raddr     = AW'(held_q - 5'd1);

	always_comb begin
		tok_d     = tok_q;
		held_d    = held_q;
		verdict_d = VERDICT_PASS;
		rel_d     = 1'b0;
		we        = 1'b0;
		re        = 1'b0;
		if (ent_cls.tick) begin
			verdict_d = VERDICT_NONE;
			if (held_q != '0) begin
				held_d = held_q - 5'd1;
				rel_d  = 1'b1;
				re     = exec;
			end
			if (tok_q < token_cap) begin
				tok_d = tok_q + 8'd1;
			end
		end else if (ent_cls.limited) begin
			if (tok_q != '0) begin
				tok_d = tok_q - 8'd1;
			end else if (held_q < eff_limit) begin
				held_d    = held_q + 5'd1;
				verdict_d = VERDICT_HELD;
				we        = exec;
			end else begin
				verdict_d = VERDICT_DROPPED;
			end
		end
	end

	pts_ram #(
		.WIDTH(HW),
		.DEPTH(HOLD_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(ent_handle),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q       <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= ent_valid;
			end
			if (exec) begin
				tok_q  <= tok_d;
				held_q <= held_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			verdict_q <= verdict_d;
			rel_q     <= rel_d;
		end
	end

	// Read data holds while stalled, as the stack is read only on a releasing tick.
	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign release_valid  = rel_q;
	assign release_handle = rel_q ? PKT_HANDLE_W'(rdata) : '0;
	assign tokens_now     = tok_q;
	assign held_now       = held_q;

endmodule

// ===== rtl/core/packet_token_bucket_shaper.sv =====
// Flow: a beat accepted on in_valid is pushed into the queue and executed from there;
// its result is registered in the execute stage and shown with out_valid.
// Throughput: one beat per cycle while out_stall is low; a two-entry queue separates
// the classifier from the execute stage, which registers its token, hold count and stack update.
// Reset: arst_n clears the token and hold counts, the queue and the output valid,
// and loads the register defaults; the hold stack is not cleared.
`include "packet_token_bucket_shaper_defines.svh"

module packet_token_bucket_shaper #(
	parameter int HOLD_DEPTH  = pts_pkg::DEF_HOLD_DEPTH,
	parameter int HANDLE_BITS = pts_pkg::DEF_HANDLE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               func,
	input  logic [pts_pkg::PROTO_W-1:0]        protocol,
	input  logic [pts_pkg::ADDR_W-1:0]         dest_address,
	input  logic [pts_pkg::PKT_HANDLE_W-1:0]   packet_handle,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pts_pkg::VERDICT_W-1:0]      verdict,
	output logic                               release_valid,
	output logic [pts_pkg::PKT_HANDLE_W-1:0]   release_handle,
	output logic [pts_pkg::TOKEN_W-1:0]        tokens_now,
	output logic [pts_pkg::HELD_W-1:0]         held_now,
	input  logic                               cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	import pts_pkg::*;

	localparam int HW = pts_store_w(HANDLE_BITS);
	localparam int QW = $bits(pts_cls_t) + HW;

	logic [PROTO_W-1:0] match_protocol_q;
	logic [ADDR_W-1:0]  exempt_address_q;
	logic [TOKEN_W-1:0] token_cap_q;
	logic [HELD_W-1:0]  hold_limit_q;

	pts_cls_t          fr_cls;
	logic [HW-1:0]     fr_handle;
	logic              q_full;
	logic              q_valid;
	logic [QW-1:0]     q_data;
	logic              q_pop;
	pts_cls_t          q_cls;
	logic [HW-1:0]     q_handle;
	logic              res_release;
	logic              res_kept;
	logic              res_held;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_protocol_q <= RST_MATCH_PROTOCOL;
			exempt_address_q <= RST_EXEMPT_ADDRESS;
			token_cap_q      <= RST_TOKEN_CAP;
			hold_limit_q     <= RST_HOLD_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MATCH_PROTOCOL: match_protocol_q <= cfg_wdata[PROTO_W-1:0];
				REG_EXEMPT_ADDRESS: exempt_address_q <= cfg_wdata[ADDR_W-1:0];
				REG_TOKEN_CAP:      token_cap_q      <= cfg_wdata[TOKEN_W-1:0];
				REG_HOLD_LIMIT:     hold_limit_q     <= cfg_wdata[HELD_W-1:0];
				default: ;
			endcase
		end
	end

	pts_front #(
		.HANDLE_BITS(HANDLE_BITS)
	) u_front (
		.func          (func),
		.protocol      (protocol),
		.dest_address  (dest_address),
		.packet_handle (packet_handle),
		.match_protocol(match_protocol_q),
		.exempt_address(exempt_address_q),
		.cls           (fr_cls),
		.handle        (fr_handle)
	);

	pts_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_data({fr_cls, fr_handle}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_data (q_data)
	);

	assign in_stall = q_full;
	assign q_cls    = q_data[QW-1:HW];
	assign q_handle = q_data[HW-1:0];

	pts_back #(
		.HOLD_DEPTH (HOLD_DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ent_valid     (q_valid),
		.ent_cls       (q_cls),
		.ent_handle    (q_handle),
		.ent_pop       (q_pop),
		.token_cap     (token_cap_q),
		.hold_limit    (hold_limit_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.release_valid (release_valid),
		.release_handle(release_handle),
		.tokens_now    (tokens_now),
		.held_now      (held_now)
	);

	assign res_release = out_valid && release_valid;
	assign res_kept    = out_valid && (verdict == VERDICT_DROPPED || verdict == VERDICT_HELD);
	assign res_held    = out_valid && (verdict == VERDICT_HELD);

	// A release only ever comes from a tick.
	`PTS_ASSERT_NOW(a_release_on_tick, res_release, verdict == VERDICT_NONE, "release on a packet")
	// A packet is held or dropped only when no token was left.
	`PTS_ASSERT_NOW(a_drop_no_token, res_kept, tokens_now == '0, "hold or drop with tokens left")
	`PTS_ASSERT_NOW(a_held_nonzero, res_held, held_now != '0, "held verdict with empty stack")

endmodule
